### rtl/dhp_pkg.sv
// Package for the decimal/hex number parser.
// Holds the parse phase type, the control-state struct and character codes.
// No dependencies.
package dhp_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SKIP,
        PH_SIGN,
        PH_ZERO,
        PH_INT,
        PH_FRAC,
        PH_HEX
    } t_phase;

    // Control part of the parse state; the magnitude travels beside it
    typedef struct packed {
        t_phase     phase;
        logic       negative;
        logic       sat;
        logic [7:0] frac_count;
        logic [7:0] char_count;
        logic [7:0] step_count;
    } t_ctl;

    localparam logic [7:0] CH_NUL    = 8'd0;
    localparam logic [7:0] CH_SPACE1 = 8'd33;   // bytes from 1 up to below this are skipped
    localparam logic [7:0] CH_COMMA  = 8'd44;
    localparam logic [7:0] CH_MINUS  = 8'd45;
    localparam logic [7:0] CH_POINT  = 8'd46;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_NINE   = 8'd57;
    localparam logic [7:0] CH_COLON  = 8'd58;
    localparam logic [7:0] CH_SEMI   = 8'd59;
    localparam logic [7:0] CH_EQUAL  = 8'd61;
    localparam logic [7:0] CH_UC_A   = 8'd65;
    localparam logic [7:0] CH_UC_F   = 8'd70;
    localparam logic [7:0] CH_LC_A   = 8'd97;
    localparam logic [7:0] CH_LC_F   = 8'd102;
    localparam logic [7:0] CH_X      = 8'd120;
    localparam logic [7:0] UC_OFFSET = 8'd7;
    localparam logic [7:0] LC_OFFSET = 8'd39;
    localparam logic [7:0] CHAR_MAX  = 8'd255;

endpackage

### rtl/decimal_hex_number_parser.sv
// Top level of the ASCII decimal/hex number parser.
// Uses dhp_pkg, dhp_in_reg (input register) and dhp_step (per-character logic).
//
//  channel  direction  handshake          payload
//  input    in         i_valid / o_stall  i_ch, i_start_req
//  result   out        o_valid / i_stall  o_mantissa, o_frac_digits, o_consumed
//
// One character per cycle, sustained while the result is not stalled. A character is
// held in the input register, then the step logic updates the parse state and, at the
// end of a number, loads the result register. Synchronous active-low reset puts the
// parser idle; characters without a start are then dropped. A stalled result holds
// the step, and the input register raises o_stall only while it holds a character
// that cannot advance.
module decimal_hex_number_parser #(
    parameter int MAX_STEPS     = 255,
    parameter int MANTISSA_BITS = 47
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_ch,
    input  logic               i_start_req,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [47:0] o_mantissa,
    output logic [7:0]         o_frac_digits,
    output logic [7:0]         o_consumed
);
    import dhp_pkg::*;

    logic                     w_load;
    logic                     w_adv;
    logic                     w_in_valid;
    logic [7:0]               w_in_ch;
    logic                     w_in_start;

    t_ctl                     r_ctl;
    t_ctl                     n_ctl;
    logic [MANTISSA_BITS-1:0] r_mag;
    logic [MANTISSA_BITS-1:0] n_mag;
    logic                     w_emit;

    logic                     r_out_valid;
    logic signed [47:0]       r_mantissa;
    logic [7:0]               r_frac_digits;
    logic [7:0]               r_consumed;
    logic signed [MANTISSA_BITS:0] w_signed;

    // advance the held character when the result register can take a result
    assign w_adv   = w_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = w_in_valid && !w_adv;
    assign w_load  = i_valid && !o_stall;

    dhp_in_reg u_in_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_consume   (w_adv),
        .i_ch        (i_ch),
        .i_start_req (i_start_req),
        .o_valid     (w_in_valid),
        .o_ch        (w_in_ch),
        .o_start_req (w_in_start)
    );

    dhp_step #(
        .MANTISSA_BITS (MANTISSA_BITS),
        .MAX_STEPS     (MAX_STEPS)
    ) u_step (
        .i_ctl   (r_ctl),
        .i_mag   (r_mag),
        .i_ch    (w_in_ch),
        .i_start (w_in_start),
        .o_ctl   (n_ctl),
        .o_mag   (n_mag),
        .o_emit  (w_emit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '{phase: PH_IDLE, negative: 1'b0, sat: 1'b0,
                       frac_count: 8'd0, char_count: 8'd0, step_count: 8'd0};
            r_mag <= '0;
        end else if (w_adv) begin
            r_ctl <= n_ctl;
            r_mag <= n_mag;
        end
    end

    assign w_signed = n_ctl.negative ? -$signed({1'b0, n_mag}) : $signed({1'b0, n_mag});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            r_mantissa    <= 48'(w_signed);
            r_frac_digits <= n_ctl.frac_count;
            r_consumed    <= n_ctl.char_count;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_mantissa    = r_mantissa;
    assign o_frac_digits = r_frac_digits;
    assign o_consumed    = r_consumed;
endmodule

### rtl/dhp_in_reg.sv
// Input register of the number parser: one held character transfer.
// Depends on nothing; the top level decides when the held item is consumed.
module dhp_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  logic       i_consume,
    input  logic [7:0] i_ch,
    input  logic       i_start_req,
    output logic       o_valid,
    output logic [7:0] o_ch,
    output logic       o_start_req
);
    logic       r_valid;
    logic [7:0] r_ch;
    logic       r_start_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_consume) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ch        <= i_ch;
            r_start_req <= i_start_req;
        end
    end

    assign o_valid     = r_valid;
    assign o_ch        = r_ch;
    assign o_start_req = r_start_req;
endmodule

### rtl/dhp_step.sv
// One-character step of the parser: next parse state and end-of-number flag.
// Uses dhp_pkg for the phase type, the control struct and character codes.
module dhp_step #(
    parameter int MANTISSA_BITS = 47,
    parameter int MAX_STEPS     = 255
) (
    input  dhp_pkg::t_ctl             i_ctl,
    input  logic [MANTISSA_BITS-1:0]  i_mag,
    input  logic [7:0]                i_ch,
    input  logic                      i_start,
    output dhp_pkg::t_ctl             o_ctl,
    output logic [MANTISSA_BITS-1:0]  o_mag,
    output logic                      o_emit
);
    import dhp_pkg::*;

    localparam int         WW      = MANTISSA_BITS + 4;
    localparam logic [7:0] STEP_CAP = 8'(MAX_STEPS);
    localparam logic [MANTISSA_BITS-1:0] MAG_MAX = '1;

    t_ctl                     ctl;
    logic [MANTISSA_BITS-1:0] mag;
    logic                     emit;
    logic                     do_dec;
    logic [7:0]               hex_m;
    logic [3:0]               dig;
    logic [WW-1:0]            wide;
    logic                     ovf;

    always_comb begin
        ctl    = i_ctl;
        mag    = i_mag;
        emit   = 1'b0;
        do_dec = 1'b0;
        hex_m  = i_ch;
        dig    = i_ch[3:0];
        wide   = '0;
        ovf    = 1'b0;

        if (i_start) begin
            ctl.phase      = PH_SKIP;
            ctl.negative   = 1'b0;
            ctl.sat        = 1'b0;
            ctl.frac_count = '0;
            ctl.char_count = '0;
            ctl.step_count = '0;
            mag            = '0;
        end

        case (ctl.phase)
            PH_SKIP: begin
                if (i_ch == CH_NUL) begin
                    emit = 1'b1;
                end else if (i_ch < CH_SPACE1 || i_ch == CH_EQUAL || i_ch == CH_COMMA
                             || i_ch == CH_SEMI || i_ch == CH_COLON) begin
                    if (ctl.char_count != CHAR_MAX) ctl.char_count = ctl.char_count + 8'd1;
                    ctl.step_count = ctl.step_count + 8'd1;
                    if (ctl.step_count >= STEP_CAP) emit = 1'b1;
                end else if (i_ch == CH_MINUS) begin
                    ctl.negative = 1'b1;
                    if (ctl.char_count != CHAR_MAX) ctl.char_count = ctl.char_count + 8'd1;
                    ctl.phase = PH_SIGN;
                end else if (i_ch == CH_ZERO) begin
                    if (ctl.char_count != CHAR_MAX) ctl.char_count = ctl.char_count + 8'd1;
                    ctl.phase = PH_ZERO;
                end else if (i_ch > CH_ZERO && i_ch <= CH_NINE) begin
                    ctl.phase = PH_INT;
                    do_dec    = 1'b1;
                end else begin
                    emit = 1'b1;
                end
            end
            PH_SIGN: begin
                if (i_ch == CH_ZERO) begin
                    if (ctl.char_count != CHAR_MAX) ctl.char_count = ctl.char_count + 8'd1;
                    ctl.phase = PH_ZERO;
                end else begin
                    ctl.phase = PH_INT;
                    do_dec    = 1'b1;
                end
            end
            PH_ZERO: begin
                if (i_ch == CH_X) begin
                    if (ctl.char_count != CHAR_MAX) ctl.char_count = ctl.char_count + 8'd1;
                    ctl.step_count = '0;
                    mag            = '0;
                    ctl.phase      = PH_HEX;
                end else begin
                    // the held zero counts as a decimal step
                    ctl.step_count = ctl.step_count + 8'd1;
                    ctl.phase      = PH_INT;
                    if (ctl.step_count >= STEP_CAP) begin
                        emit = 1'b1;
                    end else begin
                        do_dec = 1'b1;
                    end
                end
            end
            PH_INT, PH_FRAC: begin
                do_dec = 1'b1;
            end
            PH_HEX: begin
                // letters fold onto the codes just above '9'
                if (i_ch >= CH_UC_A && i_ch <= CH_UC_F) begin
                    hex_m = i_ch - UC_OFFSET;
                end else if (i_ch >= CH_LC_A && i_ch <= CH_LC_F) begin
                    hex_m = i_ch - LC_OFFSET;
                end
                if (hex_m[7:4] != CH_ZERO[7:4]) begin
                    emit = 1'b1;
                end else begin
                    dig  = hex_m[3:0];
                    wide = {mag, 4'b0000} + WW'(dig);
                    ovf  = (wide[WW-1:MANTISSA_BITS] != 4'd0);
                    if (ctl.sat || ovf) begin
                        mag     = MAG_MAX;
                        ctl.sat = 1'b1;
                    end else begin
                        mag = wide[MANTISSA_BITS-1:0];
                    end
                    if (ctl.char_count != CHAR_MAX) ctl.char_count = ctl.char_count + 8'd1;
                    ctl.step_count = ctl.step_count + 8'd1;
                    if (ctl.step_count >= STEP_CAP) emit = 1'b1;
                end
            end
            default: begin
                ctl.phase = PH_IDLE;
            end
        endcase

        if (do_dec) begin
            if (i_ch >= CH_ZERO && i_ch <= CH_NINE) begin
                if (ctl.phase != PH_FRAC) ctl.phase = PH_INT;
                dig  = i_ch[3:0];
                wide = (WW'(mag) << 3) + (WW'(mag) << 1) + WW'(dig);
                ovf  = (wide[WW-1:MANTISSA_BITS] != 4'd0);
                if (ctl.phase == PH_FRAC) begin
                    // an overflowing fraction digit is dropped with all after it
                    if (!ctl.sat) begin
                        if (ovf) begin
                            ctl.sat = 1'b1;
                        end else begin
                            mag            = wide[MANTISSA_BITS-1:0];
                            ctl.frac_count = ctl.frac_count + 8'd1;
                        end
                    end
                end else if (ctl.sat || ovf) begin
                    mag     = MAG_MAX;
                    ctl.sat = 1'b1;
                end else begin
                    mag = wide[MANTISSA_BITS-1:0];
                end
                if (ctl.char_count != CHAR_MAX) ctl.char_count = ctl.char_count + 8'd1;
                ctl.step_count = ctl.step_count + 8'd1;
                if (ctl.step_count >= STEP_CAP) emit = 1'b1;
            end else if (i_ch == CH_POINT && ctl.phase != PH_FRAC) begin
                ctl.phase = PH_FRAC;
                if (ctl.char_count != CHAR_MAX) ctl.char_count = ctl.char_count + 8'd1;
                ctl.step_count = ctl.step_count + 8'd1;
                if (ctl.step_count >= STEP_CAP) emit = 1'b1;
            end else begin
                emit = 1'b1;
            end
        end

        if (emit) ctl.phase = PH_IDLE;
    end

    assign o_ctl  = ctl;
    assign o_mag  = mag;
    assign o_emit = emit;
endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// Testbench for decimal_hex_number_parser: random and directed character streams checked
// against an in-bench model of the parse. Depends on dhp_pkg and the parser RTL.
module tb;
    import dhp_pkg::*;

    localparam int MAX_STEPS       = 255;
    localparam int MANTISSA_BITS   = 47;
    localparam logic [63:0] MAG_MAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - MANTISSA_BITS);
    localparam int CYCLE_LIMIT     = 400000;
    localparam int RANDOM_ITEMS    = 200;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RX_FREE         = 0;
    localparam int RX_RANDOM       = 1;
    localparam int RX_PATTERN      = 2;

    typedef struct packed {
        logic signed [47:0] mantissa;
        logic [7:0]         frac;
        logic [7:0]         consumed;
    } t_number;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [7:0]         i_ch;
    logic               i_start_req;
    logic               o_valid;
    logic               i_stall;
    logic signed [47:0] o_mantissa;
    logic [7:0]         o_frac_digits;
    logic [7:0]         o_consumed;

    decimal_hex_number_parser #(
        .MAX_STEPS     (MAX_STEPS),
        .MANTISSA_BITS (MANTISSA_BITS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_ch          (i_ch),
        .i_start_req   (i_start_req),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_mantissa    (o_mantissa),
        .o_frac_digits (o_frac_digits),
        .o_consumed    (o_consumed)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Parse state as the bench sees it
    t_phase      num_phase;
    logic [63:0] num_mag;
    bit          num_neg;
    bit          num_sat;
    int          num_frac;
    int          num_chars;
    int          num_steps;
    t_number     expected_numbers[$];

    logic [7:0]  text_q[$];
    int          errors;
    int          cycles;
    int          items_sent;
    int          burst_left;
    bit          sender_gaps;
    bit          hold_req;
    int          rx_mode;

    function automatic void clear_number();
        num_phase = PH_IDLE;
        num_mag   = '0;
        num_neg   = 1'b0;
        num_sat   = 1'b0;
        num_frac  = 0;
        num_chars = 0;
        num_steps = 0;
    endfunction

    function automatic void end_number();
        logic [63:0] m;
        t_number     n;
        m = num_mag & MAG_MAX;
        if (num_neg)
            m = 64'd0 - m;
        n.mantissa = m[47:0];
        n.frac     = num_frac[7:0];
        n.consumed = num_chars[7:0];
        expected_numbers.push_back(n);
        num_phase = PH_IDLE;
    endfunction

    function automatic void count_char();
        if (num_chars < 255)
            num_chars++;
    endfunction

    // Add one decimal digit; return 1 when the step cap ends the parse
    function automatic bit take_digit(int d);
        if (num_phase == PH_FRAC) begin
            // drop this and every later fraction digit once it would overflow
            if (!num_sat) begin
                if (num_mag > (MAG_MAX - d) / 10) begin
                    num_sat = 1'b1;
                end else begin
                    num_mag  = num_mag * 10 + d;
                    num_frac = (num_frac + 1) & 255;
                end
            end
        end else if (num_sat || num_mag > (MAG_MAX - d) / 10) begin
            num_mag = MAG_MAX;
            num_sat = 1'b1;
        end else begin
            num_mag = num_mag * 10 + d;
        end
        count_char();
        num_steps++;
        return num_steps >= MAX_STEPS;
    endfunction

    function automatic void take_decimal_byte(int c);
        if (c >= CH_ZERO && c <= CH_NINE) begin
            if (num_phase != PH_FRAC)
                num_phase = PH_INT;
            if (take_digit(c - CH_ZERO))
                end_number();
        end else if (c == CH_POINT && num_phase != PH_FRAC) begin
            num_phase = PH_FRAC;
            count_char();
            num_steps++;
            if (num_steps >= MAX_STEPS)
                end_number();
        end else begin
            end_number();
        end
    endfunction

    function automatic void parse_char(logic [7:0] ch, bit start);
        int c;
        int m;
        int d;
        c = ch;
        if (start) begin
            clear_number();
            num_phase = PH_SKIP;
        end
        case (num_phase)
            PH_IDLE: ;
            PH_SKIP: begin
                if (c == CH_NUL) begin
                    end_number();
                end else if (c < CH_SPACE1 || c == CH_EQUAL || c == CH_COMMA ||
                             c == CH_SEMI || c == CH_COLON) begin
                    count_char();
                    num_steps++;
                    if (num_steps >= MAX_STEPS)
                        end_number();
                end else if (c == CH_MINUS) begin
                    num_neg = 1'b1;
                    count_char();
                    num_phase = PH_SIGN;
                end else if (c == CH_ZERO) begin
                    count_char();
                    num_phase = PH_ZERO;
                end else if (c > CH_ZERO && c <= CH_NINE) begin
                    num_phase = PH_INT;
                    take_decimal_byte(c);
                end else begin
                    end_number();
                end
            end
            PH_SIGN: begin
                if (c == CH_ZERO) begin
                    count_char();
                    num_phase = PH_ZERO;
                end else begin
                    num_phase = PH_INT;
                    take_decimal_byte(c);
                end
            end
            PH_ZERO: begin
                if (c == CH_X) begin
                    count_char();
                    num_steps = 0;
                    num_mag   = '0;
                    num_phase = PH_HEX;
                end else begin
                    // the held zero becomes a decimal digit
                    num_steps++;
                    num_phase = PH_INT;
                    if (num_steps >= MAX_STEPS)
                        end_number();
                    else
                        take_decimal_byte(c);
                end
            end
            PH_INT, PH_FRAC: take_decimal_byte(c);
            PH_HEX: begin
                m = c;
                if (m >= CH_UC_A && m <= CH_UC_F)
                    m -= UC_OFFSET;
                else if (m >= CH_LC_A && m <= CH_LC_F)
                    m -= LC_OFFSET;
                if (m < CH_ZERO || m > CH_ZERO + 15) begin
                    end_number();
                end else begin
                    d = m - CH_ZERO;
                    if (num_sat || num_mag > ((MAG_MAX - d) >> 4)) begin
                        num_mag = MAG_MAX;
                        num_sat = 1'b1;
                    end else begin
                        num_mag = (num_mag << 4) + d;
                    end
                    count_char();
                    num_steps++;
                    if (num_steps >= MAX_STEPS)
                        end_number();
                end
            end
            default: num_phase = PH_IDLE;
        endcase
    endfunction

    function automatic logic [7:0] pick_separator();
        case ($urandom_range(0, 5))
            0: return CH_COMMA;
            1: return CH_SEMI;
            2: return CH_COLON;
            3: return CH_EQUAL;
            default: return 8'($urandom_range(1, 32));
        endcase
    endfunction

    // Hex digits, including the colon-to-question-mark range
    function automatic logic [7:0] pick_hex_digit();
        case ($urandom_range(0, 3))
            0: return 8'(CH_ZERO + $urandom_range(0, 9));
            1: return 8'(CH_UC_A + $urandom_range(0, 5));
            2: return 8'(CH_LC_A + $urandom_range(0, 5));
            default: return 8'(CH_COLON + $urandom_range(0, 5));
        endcase
    endfunction

    // Drive one character and hold it until the transfer
    task automatic send_char(input logic [7:0] ch, input bit start);
        int gap;
        if (sender_gaps && burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = $urandom_range(1, 8);
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        if (burst_left > 0)
            burst_left--;
        i_valid     = 1'b1;
        i_ch        = ch;
        i_start_req = start;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        if (start || num_phase != PH_IDLE)
            items_sent++;
        parse_char(ch, start);
        @(negedge i_clk);
    endtask

    task automatic send_text();
        foreach (text_q[k])
            send_char(text_q[k], k == 0);
    endtask

    task automatic test_directed();
        sender_gaps = 1'b1;
        rx_mode = RX_RANDOM;
        text_q = '{CH_NUL};
        send_text();
        text_q = '{CH_COMMA, "7", CH_POINT, "5", CH_POINT};
        send_text();
        text_q = '{CH_MINUS, "0", "x", "?", "F", "g"};
        send_text();
        text_q = '{"0", "x", "a", ":", " "};
        send_text();
        text_q = '{"0", "9", CH_NUL};
        send_text();
        text_q = '{"A"};
        send_text();
        text_q = '{CH_MINUS, "0", " "};
        send_text();
        // no parse active: dropped
        send_char("Z", 1'b0);
        text_q = '{8'hFF};
        send_text();
    endtask

    // Receiver holds off while single-digit numbers keep coming
    task automatic test_stall_fill();
        sender_gaps = 1'b0;
        rx_mode = RX_FREE;
        hold_req = 1'b1;
        repeat (24) begin
            text_q = '{8'(CH_ZERO + $urandom_range(0, 9)), CH_NUL};
            send_text();
        end
    endtask

    task automatic send_random_token();
        int n;
        if ($urandom_range(0, 99) < 8) begin
            repeat ($urandom_range(1, 6))
                send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            return;
        end
        text_q = {};
        repeat ($urandom_range(0, 2))
            text_q.push_back(pick_separator());
        if ($urandom_range(0, 3) == 0)
            text_q.push_back(CH_MINUS);
        if ($urandom_range(0, 2) == 0) begin
            text_q.push_back("0");
            text_q.push_back(CH_X);
            repeat ($urandom_range(0, 14))
                text_q.push_back(pick_hex_digit());
        end else begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : $urandom_range(0, 6);
            repeat (n)
                text_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
            if ($urandom_range(0, 1) == 0) begin
                text_q.push_back(CH_POINT);
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 5);
                repeat (n)
                    text_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                if ($urandom_range(0, 5) == 0)
                    text_q.push_back(CH_POINT);
            end
        end
        // without a terminator the next start abandons the parse
        case ($urandom_range(0, 7))
            0, 1, 2: text_q.push_back(CH_NUL);
            3, 4:    text_q.push_back(" ");
            5, 6:    text_q.push_back(8'($urandom_range(0, 255)));
            default: ;
        endcase
        send_text();
    endtask

    task automatic test_random_numbers();
        int target;
        int next_switch;
        target = items_sent + RANDOM_ITEMS;
        next_switch = items_sent;
        while (items_sent < target) begin
            if (items_sent >= next_switch) begin
                sender_gaps = $urandom_range(0, 2) != 0;
                rx_mode = $urandom_range(RX_FREE, RX_PATTERN);
                next_switch = items_sent + 150;
            end
            send_random_token();
        end
    endtask

    // Long runs that reach the step cap, saturation and the consumed limit
    task automatic test_step_cap();
        for (int kind = 0; kind < 5; kind++) begin
            sender_gaps = $urandom_range(0, 1);
            rx_mode = $urandom_range(RX_FREE, RX_PATTERN);
            text_q = {};
            case (kind)
                0: repeat (300) text_q.push_back(pick_separator());
                1: begin
                    text_q.push_back(CH_MINUS);
                    text_q.push_back(8'(CH_ZERO + $urandom_range(1, 9)));
                    repeat (270) text_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                end
                2: begin
                    text_q = '{CH_MINUS, "0", CH_X};
                    repeat (258) text_q.push_back(pick_hex_digit());
                end
                3: begin
                    text_q = '{8'(CH_ZERO + $urandom_range(1, 9)), CH_POINT};
                    repeat (260) text_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                end
                default: begin
                    text_q.push_back("0");
                    repeat (260) text_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                end
            endcase
            text_q.push_back(CH_NUL);
            send_text();
        end
    endtask

    // Receiver: long hold-off on request, otherwise its own stall pattern
    initial begin
        int tick;
        i_stall = 1'b0;
        tick = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall = 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            tick++;
            case (rx_mode)
                RX_RANDOM:  i_stall = $urandom_range(0, 99) < 35;
                RX_PATTERN: i_stall = (tick % 9) < 4;
                default:    i_stall = 1'b0;
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_number want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_numbers.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual %0d/%0d/%0d",
                         $time, o_mantissa, o_frac_digits, o_consumed);
            end else begin
                want = expected_numbers.pop_front();
                if (o_mantissa !== want.mantissa) begin
                    errors++;
                    $display("%0t: mantissa expected %0d actual %0d",
                             $time, want.mantissa, o_mantissa);
                end
                if (o_frac_digits !== want.frac) begin
                    errors++;
                    $display("%0t: frac_digits expected %0d actual %0d",
                             $time, want.frac, o_frac_digits);
                end
                if (o_consumed !== want.consumed) begin
                    errors++;
                    $display("%0t: consumed expected %0d actual %0d",
                             $time, want.consumed, o_consumed);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_ch        = '0;
        i_start_req = 1'b0;
        hold_req    = 1'b0;
        rx_mode     = RX_FREE;
        sender_gaps = 1'b0;
        burst_left  = 0;
        items_sent  = 0;
        errors      = 0;
        cycles      = 0;
        clear_number();
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_stall_fill();
        test_random_numbers();
        test_step_cap();

        i_valid = 1'b0;
        while (expected_numbers.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
